### hdl/ggc_pkg.sv
// ----------------------------------------------------------------------------
// ggc_pkg - shared types and constants for the greedy graph coloring block
// Field widths, default sizes and the epoch tag used to retire colored marks.
// ----------------------------------------------------------------------------
package ggc_pkg;

    // item field widths
    localparam int VERTEX_W = 10;
    localparam int COLOR_W  = 6;
    localparam int COUNT_W  = 7;

    // default sizes
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_COLORS_DEF   = 64;

    // graph epoch tag kept next to each stored color; tag zero means never colored
    localparam int EPOCH_W = 8;

    typedef logic [VERTEX_W-1:0] vertex_t;
    typedef logic [COLOR_W-1:0]  color_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [EPOCH_W-1:0]  epoch_t;

endpackage

### hdl/ggc_if.sv
// ----------------------------------------------------------------------------
// ggc_if - item channels of the greedy graph coloring block
// Valid/ready channels for neighbor entries and for coloring results.
// ----------------------------------------------------------------------------
interface ggc_vertex_if;
    import ggc_pkg::*;

    logic    valid;
    logic    ready;
    logic    start_graph;
    vertex_t vertex;
    vertex_t neighbor;
    logic    has_neighbor;
    logic    last_neighbor;

    modport source (
        output valid, start_graph, vertex, neighbor, has_neighbor, last_neighbor,
        input  ready
    );

    modport sink (
        input  valid, start_graph, vertex, neighbor, has_neighbor, last_neighbor,
        output ready
    );
endinterface

interface ggc_color_if;
    import ggc_pkg::*;

    logic    valid;
    logic    ready;
    vertex_t colored_vertex;
    color_t  assigned_color;
    count_t  colors_used;
    logic    no_free_color;

    modport source (
        output valid, colored_vertex, assigned_color, colors_used, no_free_color,
        input  ready
    );

    modport sink (
        input  valid, colored_vertex, assigned_color, colors_used, no_free_color,
        output ready
    );
endinterface

### hdl/greedy_graph_coloring.sv
// ----------------------------------------------------------------------------
// greedy_graph_coloring - first-fit greedy vertex coloring
// Path: a last neighbor entry is held in the entry stage, then its result goes to the result register.
// Throughput: one neighbor entry per cycle; entries stall only while the result
//   register holds an untaken result, or during a clearing pass.
// Reset: a clearing pass sweeps every entry of the color memory first;
//   the same pass runs once every 255 start_graph items, when the epoch wraps.
// ----------------------------------------------------------------------------
module greedy_graph_coloring #(
    parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_COLORS   = ggc_pkg::MAX_COLORS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    ggc_vertex_if.sink vertex_stream,
    ggc_color_if.source color_stream
);
    import ggc_pkg::*;

    // Each memory entry is {epoch tag, color}. A vertex counts as colored in the
    // current graph only when its tag equals the running epoch, so start_graph
    // clears every mark at once by moving to the next epoch. When the epoch runs
    // out, the memory is swept back to tag zero and counting restarts at one.

    localparam int     ADDR_W      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int     ENTRY_W     = EPOCH_W + COLOR_W;
    localparam epoch_t EPOCH_FIRST = EPOCH_W'(1);
    localparam epoch_t EPOCH_LAST  = {EPOCH_W{1'b1}};
    localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(MAX_VERTICES - 1);
    localparam color_t COLOR_TOP   = COLOR_W'(MAX_COLORS - 1);

    typedef logic [ENTRY_W-1:0]    entry_t;
    typedef logic [MAX_COLORS-1:0] used_t;

    // color memory
    entry_t mem [MAX_VERTICES];

    // graph state
    used_t  used_reg;
    color_t highest_reg;
    epoch_t epoch_reg;

    // clearing pass
    logic              sweep_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;

    // entry stage: accepted item plus registered memory read of its neighbor
    logic    s1_valid_reg;
    logic    s1_start_reg;
    vertex_t s1_vertex_reg;
    logic    s1_nb_ok_reg;
    logic    s1_last_reg;
    logic    s1_fwd_hit_reg;
    entry_t  s1_fwd_data_reg;
    entry_t  s1_rd_data_reg;

    // result register
    logic    out_valid_reg;
    vertex_t out_vertex_reg;
    color_t  out_color_reg;
    count_t  out_count_reg;
    logic    out_none_reg;

    // combinational
    logic              accept;
    logic              out_free;
    logic              s1_advance;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            s1_entry;
    epoch_t            s1_tag;
    color_t            s1_col;
    logic              nb_hit;
    used_t             used_cur;
    color_t            pick;
    logic              none_free;
    color_t            high_base;
    color_t            high_new;
    logic              vtx_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    // ---------------------------------------------------------------- handshake
    assign out_free   = !out_valid_reg || color_stream.ready;
    // a last entry moves on only when the result register can take its result
    assign s1_advance = s1_valid_reg && !sweep_reg && (!s1_last_reg || out_free);
    assign vertex_stream.ready = !sweep_reg && (!s1_valid_reg || s1_advance);
    assign accept     = vertex_stream.valid && vertex_stream.ready;

    assign rd_addr    = ADDR_W'(vertex_stream.neighbor);

    // ---------------------------------------------------------------- coloring
    // The write of the item ahead lands on the same edge as this item's read,
    // so that one write is forwarded; any older write is already in memory.
    assign s1_entry = s1_fwd_hit_reg ? s1_fwd_data_reg : s1_rd_data_reg;
    assign s1_tag   = s1_entry[ENTRY_W-1 -: EPOCH_W];
    assign s1_col   = s1_entry[COLOR_W-1:0];
    // start_graph wipes the marks before the entry is looked at
    assign nb_hit   = s1_nb_ok_reg && !s1_start_reg && (s1_tag == epoch_reg);

    always_comb
    begin
        used_cur = s1_start_reg ? '0 : used_reg;
        for (int c = 0; c < MAX_COLORS; c++)
        begin
            if (nb_hit && (s1_col == COLOR_W'(c)))
            begin
                used_cur[c] = 1'b1;
            end
        end
    end

    // first fit: lowest clear bit wins; all set falls back to the top color
    always_comb
    begin
        pick      = COLOR_TOP;
        none_free = 1'b1;
        for (int c = MAX_COLORS - 1; c >= 0; c--)
        begin
            if (!used_cur[c])
            begin
                pick      = COLOR_W'(c);
                none_free = 1'b0;
            end
        end
    end

    assign high_base = s1_start_reg ? '0 : highest_reg;
    assign high_new  = (pick > high_base) ? pick : high_base;
    // vertices past the memory are reported but not stored
    assign vtx_ok    = int'(s1_vertex_reg) < MAX_VERTICES;

    // single write port: clearing pass or the coloring of the entry stage
    always_comb
    begin
        if (sweep_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s1_advance && s1_last_reg && vtx_ok;
            wr_addr = ADDR_W'(s1_vertex_reg);
            wr_data = {epoch_reg, pick};
        end
    end

    // ---------------------------------------------------------------- memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            s1_rd_data_reg <= mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            used_reg      <= '0;
            highest_reg   <= '0;
            epoch_reg     <= EPOCH_FIRST;
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                used_reg    <= s1_last_reg ? '0 : used_cur;
                highest_reg <= s1_last_reg ? high_new : high_base;
            end

            // new graph: next epoch, or sweep when the tags run out. The start
            // item waits in the entry stage until the sweep is done.
            if (accept && vertex_stream.start_graph)
            begin
                if (epoch_reg == EPOCH_LAST)
                begin
                    epoch_reg <= EPOCH_FIRST;
                    sweep_reg <= 1'b1;
                end
                else
                begin
                    epoch_reg <= epoch_reg + EPOCH_FIRST;
                end
            end

            if (sweep_reg)
            begin
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    sweep_reg     <= 1'b0;
                    sweep_cnt_reg <= '0;
                end
                else
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
                end
            end

            if (s1_advance && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (color_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_start_reg    <= vertex_stream.start_graph;
            s1_vertex_reg   <= vertex_stream.vertex;
            s1_nb_ok_reg    <= vertex_stream.has_neighbor
                               && (int'(vertex_stream.neighbor) < MAX_VERTICES);
            s1_last_reg     <= vertex_stream.last_neighbor;
            s1_fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            s1_fwd_data_reg <= wr_data;
        end
        if (s1_advance && s1_last_reg)
        begin
            out_vertex_reg <= s1_vertex_reg;
            out_color_reg  <= pick;
            out_count_reg  <= COUNT_W'(high_new) + COUNT_W'(1);
            out_none_reg   <= none_free;
        end
    end

    assign color_stream.valid          = out_valid_reg;
    assign color_stream.colored_vertex = out_vertex_reg;
    assign color_stream.assigned_color = out_color_reg;
    assign color_stream.colors_used    = out_count_reg;
    assign color_stream.no_free_color  = out_none_reg;

    // ---------------------------------------------------------------- checks
    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch tag zero is reserved for cleared entries");

    a_count_above_color: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg > COUNT_W'(out_color_reg)))
        else $error("colors_used not above assigned_color");

    a_full_gets_top: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_none_reg) |-> (out_color_reg == COLOR_TOP))
        else $error("no free color but vertex not given the top color");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> color_stream.valid)
        else $error("colored vertex produced no result");

endmodule
